// ===== src/circular_list_position_engine_defines.svh =====
// assertion macros for the list engine
`ifndef CIRCULAR_LIST_POSITION_ENGINE_DEFINES_SVH
`define CIRCULAR_LIST_POSITION_ENGINE_DEFINES_SVH
// implication checked every clock outside reset
`define CLPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication outside reset
`define CLPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/clpe_pkg.sv =====
package clpe_pkg;
    typedef enum logic [2:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_POS   = 3'd5
    } t_cmd;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic signed [31:0] removed_value;
    } t_out_item;
endpackage

// ===== src/clpe_slot_mem.sv =====
module clpe_slot_mem #(
    parameter int AW = 4,
    parameter int DW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== src/circular_list_position_engine.sv =====
// refused commands go straight from the check to the result; an insert at the front links without a walk;
//   other commands walk the links from the head, one link read per step, before linking
// throughput: one item at a time; the next is accepted only after the result has been taken
// each walk step issues a registered read of the link memory and waits for its data
// reset: synchronous active low; list empty, slot memories hold no defined contents
module circular_list_position_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  clpe_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output clpe_pkg::t_out_item o_item
);
    import clpe_pkg::*;
    `include "circular_list_position_engine_defines.svh"

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // position width covers both the 5-bit input field and count + 1
    localparam int PW = (CW + 1 > 6) ? CW + 1 : 6;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_WALK, S_WAIT, S_RD_NB, S_RD_NB2,
        S_LINK, S_LINK2, S_OUT
    } t_state;

    t_state          r_state;
    logic [2:0]      r_cmd;
    logic [31:0]     r_val;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   r_steps;
    logic [SW-1:0]   r_cur;
    logic [SW-1:0]   r_new;
    logic [SW-1:0]   r_pr;
    logic [SW-1:0]   r_nx;
    logic [CAPACITY-1:0] r_used;
    logic [SW-1:0]   r_head;
    logic [SW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic            r_ins;
    logic            r_ovalid;
    t_out_item       r_out;

    // memory ports
    logic            nx_we, pv_we, vl_we;
    logic [SW-1:0]   nx_wa, pv_wa, nx_ra, pv_ra, vl_ra;
    logic [SW-1:0]   nx_wd, pv_wd, nx_rd, pv_rd;
    logic [31:0]     vl_rd;

    clpe_slot_mem #(.AW(SW), .DW(SW)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd));
    clpe_slot_mem #(.AW(SW), .DW(SW)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd));
    clpe_slot_mem #(.AW(SW), .DW(32)) u_value (
        .i_clk(i_clk), .i_we(vl_we), .i_waddr(r_new), .i_wdata(r_val),
        .i_raddr(vl_ra), .o_rdata(vl_rd));

    // lowest free slot
    logic [SW-1:0] free_slot;
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    // walk reads the link of the current slot
    logic [PW-1:0] cnt_x;
    assign cnt_x = PW'(r_count);
    assign nx_ra = r_cur;
    assign pv_ra = r_cur;
    assign vl_ra = r_cur;

    // link writes happen in link states
    always_comb begin
        nx_we = 1'b0; nx_wa = r_new; nx_wd = r_nx;
        pv_we = 1'b0; pv_wa = r_new; pv_wd = r_pr;
        vl_we = 1'b0;
        unique case (r_state)
            S_LINK: begin
                if (r_ins) begin
                    nx_we = 1'b1; pv_we = 1'b1; vl_we = 1'b1;
                end else begin
                    nx_we = 1'b1; nx_wa = r_pr; nx_wd = r_nx;
                    pv_we = 1'b1; pv_wa = r_nx; pv_wd = r_pr;
                end
            end
            S_LINK2: begin
                nx_we = 1'b1; nx_wa = r_pr; nx_wd = r_new;
                pv_we = 1'b1; pv_wa = r_nx; pv_wd = r_new;
            end
            default: ;
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_cmd   <= i_item.cmd;
                        r_val   <= i_item.value;
                        r_state <= S_CHECK;
                        unique case (i_item.cmd)
                            CMD_INS_FIRST, CMD_DEL_FIRST: r_pos <= PW'(1);
                            CMD_INS_LAST: r_pos <= cnt_x + 1'b1;
                            CMD_DEL_LAST: r_pos <= cnt_x;
                            default: r_pos <= PW'(i_item.position);
                        endcase
                    end
                end
                S_CHECK: begin
                    r_out.status        <= ST_DONE;
                    r_out.entry_count   <= 5'(r_count);
                    r_out.removed_value <= '0;
                    r_new <= free_slot;
                    r_cur <= r_head;
                    r_state <= S_OUT;
                    if (r_cmd == CMD_INS_FIRST || r_cmd == CMD_INS_LAST
                        || r_cmd == CMD_INS_POS) begin
                        r_ins <= 1'b1;
                        if (cnt_x >= PW'(CAPACITY)) begin
                            r_out.status <= ST_FULL;
                        end else if (r_pos == '0 || r_pos > cnt_x + 1'b1) begin
                            r_out.status <= ST_BADPOS;
                        end else if (r_count == '0) begin
                            r_pr <= free_slot; r_nx <= free_slot;
                            r_head <= free_slot; r_tail <= free_slot;
                            r_state <= S_LINK;
                        end else if (r_pos == PW'(1)) begin
                            r_pr <= r_tail; r_nx <= r_head;
                            r_state <= S_LINK;
                        end else begin
                            // walk to predecessor, then read its next
                            r_steps <= r_pos - PW'(2);
                            r_state <= S_WALK;
                        end
                    end else if (r_cmd == CMD_DEL_FIRST || r_cmd == CMD_DEL_LAST
                                 || r_cmd == CMD_DEL_POS) begin
                        r_ins <= 1'b0;
                        if (r_count == '0) begin
                            r_out.status <= ST_EMPTY;
                        end else if (r_pos == '0 || r_pos > cnt_x) begin
                            r_out.status <= ST_BADPOS;
                        end else begin
                            r_steps <= r_pos - PW'(1);
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    // read issued for r_cur this cycle
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_steps != '0) begin
                        r_steps <= r_steps - 1'b1;
                        r_cur   <= nx_rd;
                        r_state <= S_WALK;
                    end else if (r_ins) begin
                        r_pr <= r_cur; r_nx <= nx_rd;
                        if (r_pos == cnt_x + 1'b1) begin
                            r_tail <= r_new;
                        end
                        r_state <= S_LINK;
                    end else begin
                        r_out.removed_value <= vl_rd;
                        r_used[r_cur] <= 1'b0;
                        r_pr <= pv_rd; r_nx <= nx_rd;
                        if (r_count == CW'(1)) begin
                            r_count <= '0;
                            r_out.entry_count <= '0;
                            r_state <= S_OUT;
                        end else begin
                            if (r_cur == r_head) r_head <= nx_rd;
                            if (r_cur == r_tail) r_tail <= pv_rd;
                            r_state <= S_LINK;
                        end
                    end
                end
                S_LINK: begin
                    if (r_ins) begin
                        r_used[r_new] <= 1'b1;
                        if (r_count != '0 && r_pos == PW'(1)) begin
                            r_head <= r_new;
                        end
                        r_count <= r_count + 1'b1;
                        r_out.entry_count <= 5'(r_count + 1'b1);
                        r_state <= (r_count == '0) ? S_OUT : S_LINK2;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_out.entry_count <= 5'(r_count - 1'b1);
                        r_state <= S_OUT;
                    end
                end
                S_LINK2: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `CLPE_ASSERT_IMP(a_count_range, 1'b1, r_count <= CW'(CAPACITY), "count beyond capacity")
    `CLPE_ASSERT_IMP(a_used_count, r_state == S_IDLE, $countones(r_used) == int'(r_count),
        "slot map disagrees with count")
    `CLPE_ASSERT_NEXT(a_out_once, r_state == S_OUT, r_ovalid, "result not presented")
endmodule

// ===== tb/circular_list_position_engine_checker.sv =====
module circular_list_position_engine_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall,
    input  clpe_pkg::t_in_item  i_item,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  clpe_pkg::t_out_item i_res,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import clpe_pkg::*;

    // shadow copy of the list, kept in plain order
    logic signed [31:0] shadow_list[$];
    t_out_item          expected_results[$];
    int                 mismatch_count;

    // apply one command to the shadow list and return the result it gives
    function automatic t_out_item list_apply(t_in_item it);
        t_out_item r;
        int        cnt;
        int        p;
        r.status = ST_DONE;
        r.removed_value = '0;
        cnt = shadow_list.size();
        p = it.position;
        case (it.cmd)
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS: begin
                if (it.cmd == CMD_INS_FIRST) p = 1;
                if (it.cmd == CMD_INS_LAST) p = cnt + 1;
                if (cnt >= CAPACITY) r.status = ST_FULL;
                else if (p < 1 || p > cnt + 1) r.status = ST_BADPOS;
                else shadow_list.insert(p - 1, it.value);
            end
            CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
                if (it.cmd == CMD_DEL_FIRST) p = 1;
                if (it.cmd == CMD_DEL_LAST) p = cnt;
                if (cnt == 0) r.status = ST_EMPTY;
                else if (p < 1 || p > cnt) r.status = ST_BADPOS;
                else begin
                    r.removed_value = shadow_list[p - 1];
                    shadow_list.delete(p - 1);
                end
            end
            default: ;
        endcase
        r.entry_count = 5'(shadow_list.size());
        return r;
    endfunction

    // predict on accepted items, compare on accepted results
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shadow_list.delete();
            expected_results.delete();
            mismatch_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && !i_stall) expected_results.push_back(list_apply(i_item));
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: %p", i_res);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_res.status
                        || want.entry_count !== i_res.entry_count
                        || want.removed_value !== i_res.removed_value) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected %p actual %p", want, i_res);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end

    assign o_fail_count = mismatch_count;
endmodule

// ===== tb/circular_list_position_engine_tb.sv =====
module circular_list_position_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clpe_pkg::*;

    localparam int CAPACITY = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b1;
    t_out_item o_item;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    int        live_guess = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circular_list_position_engine #(.CAPACITY(CAPACITY)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    circular_list_position_engine_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall(o_stall),
        .i_item(i_item), .i_res_valid(o_valid), .i_res_stall(i_stall), .i_res(o_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stalls a random number of cycles per item
    initial begin
        int wait_n;
        @(posedge i_clk);
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if (wait_n > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_n) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // send one item, with a random gap before it unless no_gap is set
    task automatic send_item(t_cmd c, logic signed [31:0] v, logic [4:0] p, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= '{cmd: c, value: v, position: p};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        case (c)
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS:
                if (live_guess < CAPACITY) live_guess++;
            default: if (live_guess > 0) live_guess--;
        endcase
    endtask

    // stimulus
    initial begin
        t_cmd c;
        logic [4:0] p;
        bit burst;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, extremes, fill and overflow, bad positions
        send_item(CMD_DEL_FIRST, 32'sd0, 5'd0, 0);
        send_item(CMD_DEL_LAST, 32'sd0, 5'd0, 0);
        send_item(CMD_DEL_POS, 32'sd0, 5'd1, 0);
        send_item(CMD_INS_POS, 32'sd5, 5'd0, 0);
        send_item(CMD_INS_POS, 32'sd5, 5'd2, 0);
        send_item(CMD_INS_POS, 32'h7fffffff, 5'd1, 0);
        send_item(CMD_DEL_POS, 32'sd0, 5'd1, 0);
        send_item(CMD_INS_FIRST, 32'h80000000, 5'd31, 0);
        send_item(CMD_INS_LAST, -32'sd1, 5'd0, 1);
        for (int k = 0; k < CAPACITY - 2; k++)
            send_item(CMD_INS_POS, $urandom, 5'(2 + k % 2), 1);
        send_item(CMD_INS_FIRST, 32'sd9, 5'd0, 0);
        send_item(CMD_INS_POS, 32'sd9, 5'd17, 0);
        send_item(CMD_DEL_POS, 32'sd0, 5'd17, 0);
        send_item(CMD_DEL_POS, 32'sd0, 5'd0, 0);
        send_item(CMD_DEL_POS, 32'sd0, 5'd16, 0);
        send_item(CMD_DEL_LAST, 32'sd0, 5'd0, 0);

        // random: mostly commands that keep the list busy, some noise
        for (int n = 0; n < 1500; n++) begin
            burst = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 5))
                0: c = CMD_INS_FIRST;
                1: c = CMD_INS_LAST;
                2: c = CMD_INS_POS;
                3: c = CMD_DEL_FIRST;
                4: c = CMD_DEL_LAST;
                default: c = CMD_DEL_POS;
            endcase
            // bias towards delete commands when the list is long
            if (live_guess > 12 && $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 2))
                    0: c = CMD_DEL_FIRST;
                    1: c = CMD_DEL_LAST;
                    default: c = CMD_DEL_POS;
                endcase
            end
            if ($urandom_range(0, 7) == 0) p = 5'($urandom);
            else p = 5'($urandom_range(1, live_guess + 1));
            send_item(c, $urandom, p, burst);
        end
        i_valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/clpe_pkg.sv
src/clpe_slot_mem.sv
src/circular_list_position_engine.sv
tb/circular_list_position_engine_checker.sv
tb/circular_list_position_engine_tb.sv
